// ===== hdl/afd_pkg.sv =====
// Package for the API frame deframer: sizes, state and status codes,
// register indexes and the controller/datapath interface structs. No dependencies.
`timescale 1ns / 1ps

package afd_pkg;

  localparam int MAX_BODY   = 32;
  localparam int ADDR_W     = $clog2(MAX_BODY);
  localparam int POS_W      = $clog2(MAX_BODY + 1);
  localparam int BYTE_POS_W = 6;
  localparam int CFG_IDX_W  = 1;

  typedef enum logic [2:0] {
    PH_HUNT,
    PH_LENHI,
    PH_LENLO,
    PH_BODY,
    PH_CKSUM,
    PH_EMIT
  } phase_t;

  typedef enum logic [1:0] {
    ST_BODY  = 2'd0,
    ST_ERROR = 2'd1,
    ST_EMPTY = 2'd2
  } status_t;

  localparam logic [CFG_IDX_W-1:0] CFG_START_BYTE = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_GOOD_SUM   = 1'b1;

  // controller -> datapath
  typedef struct packed {
    logic    take_len;
    logic    take_body;
    logic    load_single;
    status_t single_code;
    logic    start_emit;
    logic    emit;
  } afd_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic is_start;
    logic is_zero;
    logic len_ok;
    logic body_done;
    logic sum_good;
    logic count_nonzero;
    logic out_free;
    logic rd_last;
  } afd_stat_t;

endpackage

// ===== hdl/afd_ctrl.sv =====
// Frame controller: phase state machine, input stall and datapath commands.
// Depends on afd_pkg.
`timescale 1ns / 1ps

module afd_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  afd_pkg::afd_stat_t stat,
  output afd_pkg::afd_cmd_t  cmd
);

  afd_pkg::phase_t phase, phase_next;
  logic            acc;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= afd_pkg::PH_HUNT;
    end else begin
      phase <= phase_next;
    end
  end

  always_comb begin
    phase_next      = phase;
    cmd             = '0;
    cmd.single_code = afd_pkg::ST_ERROR;
    in_stall        = 1'b0;
    acc             = 1'b0;
    unique case (phase)
      afd_pkg::PH_HUNT: begin
        acc = in_valid;
        if (acc && stat.is_start) begin
          phase_next = afd_pkg::PH_LENHI;
        end
      end
      afd_pkg::PH_LENHI: begin
        acc = in_valid;
        if (acc) begin
          phase_next = stat.is_zero ? afd_pkg::PH_LENLO : afd_pkg::PH_HUNT;
        end
      end
      afd_pkg::PH_LENLO: begin
        acc = in_valid;
        if (acc) begin
          if (!stat.len_ok) begin
            phase_next = afd_pkg::PH_HUNT;
          end else begin
            cmd.take_len = 1'b1;
            phase_next   = stat.is_zero ? afd_pkg::PH_CKSUM : afd_pkg::PH_BODY;
          end
        end
      end
      afd_pkg::PH_BODY: begin
        acc = in_valid;
        if (acc) begin
          cmd.take_body = 1'b1;
          if (stat.body_done) begin
            phase_next = afd_pkg::PH_CKSUM;
          end
        end
      end
      afd_pkg::PH_CKSUM: begin
        // hold the checksum word until the output register can take a result
        in_stall = !stat.out_free;
        acc      = in_valid && stat.out_free;
        if (acc) begin
          if (stat.sum_good && stat.count_nonzero) begin
            cmd.start_emit = 1'b1;
            phase_next     = afd_pkg::PH_EMIT;
          end else begin
            cmd.load_single = 1'b1;
            cmd.single_code = stat.sum_good ? afd_pkg::ST_EMPTY : afd_pkg::ST_ERROR;
            phase_next      = afd_pkg::PH_HUNT;
          end
        end
      end
      afd_pkg::PH_EMIT: begin
        in_stall = 1'b1;
        if (stat.out_free) begin
          cmd.emit = 1'b1;
          if (stat.rd_last) begin
            phase_next = afd_pkg::PH_HUNT;
          end
        end
      end
      default: begin
        phase_next = afd_pkg::PH_HUNT;
      end
    endcase
  end

endmodule

// ===== hdl/afd_dpath.sv =====
// Frame datapath: configuration registers, length/position counters, running
// sum, body store and output register. Depends on afd_pkg.
`timescale 1ns / 1ps

module afd_dpath (
  input  logic                                clk,
  input  logic                                rst,
  input  logic [7:0]                          rx_byte,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [afd_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [7:0]                          cfg_data,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [1:0]                          status,
  output logic [7:0]                          body_byte,
  output logic [afd_pkg::BYTE_POS_W-1:0]      byte_pos,
  output logic                                last,
  input  afd_pkg::afd_cmd_t                   cmd,
  output afd_pkg::afd_stat_t                  stat
);

  logic [7:0]                  start_byte;
  logic [7:0]                  good_sum;
  logic [afd_pkg::POS_W-1:0]   body_count;
  logic [afd_pkg::POS_W-1:0]   body_pos;
  logic [afd_pkg::POS_W-1:0]   rd_pos;
  logic [afd_pkg::POS_W-1:0]   rd_pos_inc;
  logic [afd_pkg::POS_W-1:0]   body_pos_inc;
  logic [7:0]                  running_sum;
  logic [7:0]                  sum_next;
  logic [7:0]                  mem [afd_pkg::MAX_BODY];
  logic [7:0]                  rd_data;
  logic [afd_pkg::ADDR_W-1:0]  rd_addr;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      start_byte <= 8'd126;
      good_sum   <= 8'd255;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        afd_pkg::CFG_START_BYTE: start_byte <= cfg_data;
        afd_pkg::CFG_GOOD_SUM:   good_sum   <= cfg_data;
        default: ;
      endcase
    end
  end

  assign sum_next     = running_sum + rx_byte;
  assign body_pos_inc = afd_pkg::POS_W'(body_pos + 1'b1);
  assign rd_pos_inc   = afd_pkg::POS_W'(rd_pos + 1'b1);

  always_comb begin
    stat.is_start      = (rx_byte == start_byte);
    stat.is_zero       = (rx_byte == 8'd0);
    stat.len_ok        = (rx_byte <= 8'(afd_pkg::MAX_BODY));
    stat.body_done     = (body_pos_inc >= body_count);
    stat.sum_good      = (sum_next == good_sum);
    stat.count_nonzero = (body_count != '0);
    stat.out_free      = !out_valid || !out_stall;
    stat.rd_last       = (rd_pos_inc == body_count);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      body_count  <= '0;
      body_pos    <= '0;
      running_sum <= '0;
      rd_pos      <= '0;
    end else begin
      if (cmd.take_len) begin
        body_count  <= afd_pkg::POS_W'(rx_byte);
        body_pos    <= '0;
        running_sum <= '0;
      end else if (cmd.take_body) begin
        body_pos    <= body_pos_inc;
        running_sum <= sum_next;
      end
      if (cmd.start_emit) begin
        rd_pos <= '0;
      end else if (cmd.emit) begin
        rd_pos <= rd_pos_inc;
      end
    end
  end

  // read one ahead so that a result can leave every cycle while the output is not stalled
  always_comb begin
    if (cmd.start_emit) begin
      rd_addr = '0;
    end else if (cmd.emit) begin
      rd_addr = rd_pos_inc[afd_pkg::ADDR_W-1:0];
    end else begin
      rd_addr = rd_pos[afd_pkg::ADDR_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take_body) begin
      mem[body_pos[afd_pkg::ADDR_W-1:0]] <= rx_byte;
    end
    rd_data <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_single || cmd.emit) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_single) begin
      status    <= cmd.single_code;
      body_byte <= '0;
      byte_pos  <= '0;
      last      <= 1'b1;
    end else if (cmd.emit) begin
      status    <= afd_pkg::ST_BODY;
      body_byte <= rd_data;
      byte_pos  <= afd_pkg::BYTE_POS_W'(rd_pos);
      last      <= stat.rd_last;
    end
  end

endmodule

// ===== hdl/api_frame_deframer.sv =====
// API frame deframer top level: joins the frame controller and the datapath.
// Depends on afd_pkg, afd_ctrl and afd_dpath.
`timescale 1ns / 1ps

// Takes received serial bytes one word per cycle and pulls out frames of the
// form START, LEN_HI, LEN_LO, body, CHECKSUM. A frame opens on the configured
// start byte; a nonzero LEN_HI or a LEN_LO above 32 drops it and hunting
// resumes. Body words are held in a 32-entry store and summed modulo 256; the
// checksum word is added and the total compared with good_sum. A good frame
// is played out as one result per body word (status 0, byte and position,
// last on the final one); a good empty frame gives one status 2 result and a
// bad sum one status 1 result. Every word is taken without a stall, except the
// checksum word, which waits for a free output register. After a good
// nonempty checksum the input stalls while the body plays out: one result per
// cycle once the first store read has landed, while the output side does not
// stall; the single read port of the body store sets
// that pace. Configuration writes are always ready and take effect at once;
// write them only while no frame is in progress. The store needs no clearing
// after reset.
module api_frame_deframer (
  input  logic                           clk,
  input  logic                           rst,
  // received words
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [7:0]                     rx_byte,
  // results
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [1:0]                     status,
  output logic [7:0]                     body_byte,
  output logic [afd_pkg::BYTE_POS_W-1:0] byte_pos,
  output logic                           last,
  // configuration writes
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [afd_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [7:0]                     cfg_data
);

  afd_pkg::afd_cmd_t  cmd;
  afd_pkg::afd_stat_t stat;

  // phase tracking and sequencing of the readout
  afd_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  // storage, sum, counters and the output register
  afd_dpath u_dpath (
    .clk       (clk),
    .rst       (rst),
    .rx_byte   (rx_byte),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .status    (status),
    .body_byte (body_byte),
    .byte_pos  (byte_pos),
    .last      (last),
    .cmd       (cmd),
    .stat      (stat)
  );

endmodule

// ===== hdl/afd_checker.sv =====
// Port-level checks for the API frame deframer, bound to the top level.
// Depends on afd_pkg and api_frame_deframer.
`timescale 1ns / 1ps

module afd_checker (
  input logic                           clk,
  input logic                           rst,
  input logic                           out_valid,
  input logic                           out_stall,
  input logic [1:0]                     status,
  input logic [7:0]                     body_byte,
  input logic [afd_pkg::BYTE_POS_W-1:0] byte_pos,
  input logic                           last
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(status) && $stable(body_byte)
      && $stable(byte_pos) && $stable(last))
    else $error("stalled result changed");

  a_status_code: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> status == afd_pkg::ST_BODY || status == afd_pkg::ST_ERROR
      || status == afd_pkg::ST_EMPTY)
    else $error("bad status code");

  // error and empty markers stand alone and carry no byte
  a_marker_alone: assert property (@(posedge clk) disable iff (rst)
    out_valid && status != afd_pkg::ST_BODY |-> last && body_byte == 8'd0
      && byte_pos == '0)
    else $error("malformed marker result");

  // body words play out back to back in position order
  a_body_stream: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_stall && status == afd_pkg::ST_BODY && !last
      |=> out_valid && status == afd_pkg::ST_BODY
      && byte_pos == afd_pkg::BYTE_POS_W'($past(byte_pos) + 1'b1))
    else $error("body stream broken");

endmodule

bind api_frame_deframer afd_checker u_afd_checker (
  .clk       (clk),
  .rst       (rst),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .status    (status),
  .body_byte (body_byte),
  .byte_pos  (byte_pos),
  .last      (last)
);

// ===== bench/tb.sv =====
// Self-checking bench for api_frame_deframer: directed frames, then random framed traffic.
// Depends on afd_pkg and the api_frame_deframer RTL; needs no files or arguments.
`timescale 1ns / 1ps

module tb;

  localparam int DRAIN_WAIT      = 40;      // cycles for the block to settle after the last result
  localparam int CYCLE_LIMIT     = 200000;  // watchdog, far above the slowest legal run
  localparam int WORDS_PER_PHASE = 68;
  localparam int HOLD_CYCLES     = 300;     // long receiver hold-off to back up the block

  typedef struct packed {
    afd_pkg::status_t                 status;
    logic [7:0]                       body_byte;
    logic [afd_pkg::BYTE_POS_W-1:0]   byte_pos;
    logic                             last;
  } deframe_result_t;

  // One word of stimulus; typed rows carry a result fixed by hand.
  typedef struct packed {
    logic [7:0]      word;
    logic            typed;
    deframe_result_t exp;
  } stim_row_t;

  typedef enum {FR_GOOD, FR_BAD_SUM, FR_BAD_HI, FR_LONG, FR_CUT, FR_NOISE} frame_kind_t;

  logic                          clk;
  logic                          rst;
  logic                          in_valid;
  logic                          in_stall;
  logic [7:0]                    rx_byte;
  logic                          out_valid;
  logic                          out_stall;
  logic [1:0]                    status;
  logic [7:0]                    body_byte;
  logic [afd_pkg::BYTE_POS_W-1:0] byte_pos;
  logic                          last;
  logic                          cfg_valid;
  logic                          cfg_ready;
  logic [afd_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [7:0]                    cfg_data;

  // Typed expectation travels with the word so it is sampled at the same edge.
  logic                 word_typed;
  deframe_result_t      word_exp;

  api_frame_deframer dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .rx_byte   (rx_byte),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .status    (status),
    .body_byte (body_byte),
    .byte_pos  (byte_pos),
    .last      (last),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Frame predictor: its own copy of the settings, phase, body store and sum.
  // ---------------------------------------------------------------------------
  logic [7:0]       frame_start = 8'd126;
  logic [7:0]       good_total  = 8'd255;
  afd_pkg::phase_t  frame_phase = afd_pkg::PH_HUNT;
  logic [6:0]       decl_len    = '0;
  logic [6:0]       body_taken  = '0;
  logic [7:0]       body_sum    = '0;
  logic [7:0]       body_mem [afd_pkg::MAX_BODY];

  deframe_result_t fresh[$];     // results caused by the word just taken
  deframe_result_t pending[$];   // results still due from the block

  int mismatches   = 0;
  int words_sent   = 0;
  int results_seen = 0;
  int good_frames  = 0;
  int sum_errors   = 0;
  int empty_frames = 0;
  int cycles       = 0;

  // Advance the frame state by one received word and collect what it causes.
  function automatic void predict_word(input logic [7:0] w);
    fresh.delete();
    case (frame_phase)
      afd_pkg::PH_HUNT: begin
        if (w == frame_start) frame_phase = afd_pkg::PH_LENHI;
      end
      afd_pkg::PH_LENHI: begin
        // A nonzero high length byte drops the frame; it is not rechecked as a start.
        frame_phase = (w == 8'd0) ? afd_pkg::PH_LENLO : afd_pkg::PH_HUNT;
      end
      afd_pkg::PH_LENLO: begin
        if (w > afd_pkg::MAX_BODY) begin
          frame_phase = afd_pkg::PH_HUNT;
        end else begin
          decl_len    = w[6:0];
          body_taken  = '0;
          body_sum    = '0;
          frame_phase = (w == 8'd0) ? afd_pkg::PH_CKSUM : afd_pkg::PH_BODY;
        end
      end
      afd_pkg::PH_BODY: begin
        // Start bytes here are plain data: no resync inside a frame.
        if (body_taken < afd_pkg::MAX_BODY)
          body_mem[body_taken[afd_pkg::ADDR_W-1:0]] = w;
        body_sum   = body_sum + w;
        body_taken = body_taken + 7'd1;
        if (body_taken >= decl_len) frame_phase = afd_pkg::PH_CKSUM;
      end
      afd_pkg::PH_CKSUM: begin
        body_sum = body_sum + w;
        if (body_sum != good_total) begin
          fresh.push_back('{afd_pkg::ST_ERROR, 8'd0, '0, 1'b1});
        end else if (decl_len == '0) begin
          fresh.push_back('{afd_pkg::ST_EMPTY, 8'd0, '0, 1'b1});
        end else begin
          for (int i = 0; i < decl_len; i++)
            fresh.push_back('{afd_pkg::ST_BODY, body_mem[i],
                              afd_pkg::BYTE_POS_W'(i), (i + 1 == decl_len)});
        end
        frame_phase = afd_pkg::PH_HUNT;
      end
      default: frame_phase = afd_pkg::PH_HUNT;
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Scoreboard: track register writes and taken words, check every result.
  // Predict before checking so that both sides see one consistent edge.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : watch
    deframe_result_t got;
    deframe_result_t want;
    if (!rst) begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          afd_pkg::CFG_START_BYTE: frame_start = cfg_data;
          afd_pkg::CFG_GOOD_SUM:   good_total  = cfg_data;
          default: ;
        endcase
      end
      if (in_valid && !in_stall) begin
        predict_word(rx_byte);
        if (word_typed) begin
          pending.push_back(word_exp);
        end else begin
          for (int i = 0; i < fresh.size(); i++) pending.push_back(fresh[i]);
        end
      end
      if (out_valid && !out_stall) begin
        got.status    = afd_pkg::status_t'(status);
        got.body_byte = body_byte;
        got.byte_pos  = byte_pos;
        got.last      = last;
        results_seen++;
        if (got.last) begin
          case (got.status)
            afd_pkg::ST_BODY:  good_frames++;
            afd_pkg::ST_ERROR: sum_errors++;
            afd_pkg::ST_EMPTY: empty_frames++;
            default: ;
          endcase
        end
        if (pending.size() == 0) begin
          if (mismatches < 10)
            $display("cycle %0d: unexpected result status %0d byte %02h pos %0d last %0b",
                     cycles, got.status, got.body_byte, got.byte_pos, got.last);
          mismatches++;
        end else begin
          want = pending.pop_front();
          if (got.status !== want.status || got.body_byte !== want.body_byte ||
              got.byte_pos !== want.byte_pos || got.last !== want.last) begin
            if (mismatches < 10)
              $display({"cycle %0d: want status %0d byte %02h pos %0d last %0b, ",
                        "got status %0d byte %02h pos %0d last %0b"},
                       cycles, want.status, want.body_byte, want.byte_pos, want.last,
                       got.status, got.body_byte, got.byte_pos, got.last);
            mismatches++;
          end
        end
      end
    end
  end

  // Watchdog: stop a hung run.
  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles with %0d results still due", cycles, pending.size());
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Receiver: random stalls per phase, plus a counted hold-off on request.
  // ---------------------------------------------------------------------------
  int stall_pct = 0;
  int gap_pct   = 0;
  int hold_req  = 0;   // bumped by the main sequence to ask for a hold-off
  int hold_seen = 0;   // last request the receiver has acted on
  int hold_left = 0;

  always @(posedge clk) begin
    if (hold_seen != hold_req) begin
      hold_seen = hold_req;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= (stall_pct != 0) && ($urandom_range(99) < stall_pct);
    end
  end

  // ---------------------------------------------------------------------------
  // Sender side.
  // ---------------------------------------------------------------------------
  logic [7:0] link_start = 8'd126;   // settings the sender builds frames for
  logic [7:0] link_good  = 8'd255;

  function automatic stim_row_t plain(input logic [7:0] w);
    plain = '{w, 1'b0, '0};
  endfunction

  function automatic stim_row_t typed_row(input logic [7:0] w, input afd_pkg::status_t st);
    typed_row = '{w, 1'b1, '{st, 8'd0, '0, 1'b1}};
  endfunction

  // Offer one word, with a random gap first; leave valid high after the handshake
  // so the next word can follow back to back.
  task automatic send_word(input stim_row_t row);
    if (gap_pct != 0 && $urandom_range(99) < gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
      while ($urandom_range(99) < gap_pct) @(posedge clk);
    end
    in_valid   <= 1'b1;
    rx_byte    <= row.word;
    word_typed <= row.typed;
    word_exp   <= row.exp;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    words_sent++;
  endtask

  // Drop valid and hold until every due result has come back.
  task automatic wait_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending.size() != 0) @(posedge clk);
  endtask

  // Drain, let the block settle, then write both registers back to back.
  task automatic load_settings(input logic [7:0] sb, input logic [7:0] gs);
    wait_idle();
    repeat (DRAIN_WAIT) @(posedge clk);
    for (int r = 0; r < 2; r++) begin
      cfg_valid <= 1'b1;
      cfg_index <= (r == 0) ? afd_pkg::CFG_START_BYTE : afd_pkg::CFG_GOOD_SUM;
      cfg_data  <= (r == 0) ? sb : gs;
      @(posedge clk);
      while (!cfg_ready) @(posedge clk);
    end
    cfg_valid  <= 1'b0;
    link_start = sb;
    link_good  = gs;
  endtask

  // Send one frame, well formed or broken as the kind says.
  task automatic send_frame(input frame_kind_t kind, input int len);
    logic [7:0] sum;
    logic [7:0] w;
    int         n;
    sum = '0;
    case (kind)
      FR_NOISE: begin
        repeat ($urandom_range(1, 4)) send_word(plain(8'($urandom)));
      end
      FR_BAD_HI: begin
        send_word(plain(link_start));
        send_word(plain(8'($urandom_range(1, 255))));
      end
      FR_LONG: begin
        send_word(plain(link_start));
        send_word(plain(8'd0));
        send_word(plain(8'($urandom_range(afd_pkg::MAX_BODY + 1, 255))));
      end
      default: begin
        send_word(plain(link_start));
        send_word(plain(8'd0));
        send_word(plain(8'(len)));
        // A cut frame stops short; the following words get absorbed as body.
        n = (kind == FR_CUT) ? $urandom_range(0, len - 1) : len;
        repeat (n) begin
          w   = 8'($urandom);
          sum = sum + w;
          send_word(plain(w));
        end
        if (kind == FR_GOOD)
          send_word(plain(link_good - sum));
        else if (kind == FR_BAD_SUM)
          send_word(plain(link_good - sum + 8'($urandom_range(1, 255))));
      end
    endcase
  endtask

  // ---------------------------------------------------------------------------
  // Main sequence.
  // ---------------------------------------------------------------------------
  initial begin
    stim_row_t   dir_rows[$];
    frame_kind_t kind;
    int          len;
    int          pick;
    int          base;
    bit          paused;

    rst        <= 1'b1;
    in_valid   <= 1'b0;
    rx_byte    <= 8'd0;
    word_typed <= 1'b0;
    word_exp   <= '0;
    cfg_valid  <= 1'b0;
    cfg_index  <= afd_pkg::CFG_START_BYTE;
    cfg_data   <= 8'd0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // Directed words under the reset settings (start 7E, good sum FF).
    // Noise outside a frame gives nothing.
    dir_rows.push_back(plain(8'h00));
    dir_rows.push_back(plain(8'hFF));
    // Empty frame, good sum.
    dir_rows.push_back(plain(8'h7E)); dir_rows.push_back(plain(8'h00));
    dir_rows.push_back(plain(8'h00));
    dir_rows.push_back(typed_row(8'hFF, afd_pkg::ST_EMPTY));
    // Empty frame, bad sum.
    dir_rows.push_back(plain(8'h7E)); dir_rows.push_back(plain(8'h00));
    dir_rows.push_back(plain(8'h00));
    dir_rows.push_back(typed_row(8'h00, afd_pkg::ST_ERROR));
    // Nonzero high length byte drops the frame.
    dir_rows.push_back(plain(8'h7E)); dir_rows.push_back(plain(8'h01));
    // A start byte in the high length slot is just a nonzero length.
    dir_rows.push_back(plain(8'h7E)); dir_rows.push_back(plain(8'h7E));
    // Length one past the store drops the frame.
    dir_rows.push_back(plain(8'h7E)); dir_rows.push_back(plain(8'h00));
    dir_rows.push_back(plain(8'h21));
    // Two-word body holding a start byte, good sum.
    dir_rows.push_back(plain(8'h7E)); dir_rows.push_back(plain(8'h00));
    dir_rows.push_back(plain(8'h02)); dir_rows.push_back(plain(8'h7E));
    dir_rows.push_back(plain(8'hFF)); dir_rows.push_back(plain(8'h82));

    for (int i = 0; i < dir_rows.size(); i++) send_word(dir_rows[i]);

    // Random phases: each changes settings and idling, then runs framed traffic.
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: load_settings(8'h00, 8'h00);
        1: load_settings(8'hFF, 8'hFF);
        default: load_settings(8'($urandom), 8'($urandom));
      endcase
      gap_pct   = (ph == 1) ? 67 : (ph == 3) ? 38 : 0;
      stall_pct = (ph == 2) ? 67 : (ph == 3) ? 38 : 0;
      base      = words_sent;
      paused    = 1'b0;

      if (ph == 0) begin
        // Hold the output long enough for a full-length frame to back up the input.
        hold_req++;
        send_frame(FR_GOOD, afd_pkg::MAX_BODY);
      end

      while (words_sent - base < WORDS_PER_PHASE) begin
        if (!paused && words_sent - base >= WORDS_PER_PHASE / 2) begin
          wait_idle();
          paused = 1'b1;
        end
        pick = $urandom_range(99);
        kind = (pick < 55) ? FR_GOOD   : (pick < 67) ? FR_BAD_SUM :
               (pick < 75) ? FR_BAD_HI : (pick < 83) ? FR_LONG    :
               (pick < 90) ? FR_CUT    : FR_NOISE;
        case ($urandom_range(7))
          0:       len = 0;
          1:       len = afd_pkg::MAX_BODY;
          default: len = $urandom_range(1, 8);
        endcase
        if (kind == FR_CUT && len == 0) len = 1;
        send_frame(kind, len);
      end
    end

    wait_idle();
    repeat (DRAIN_WAIT) @(posedge clk);

    $display("sent %0d words over four idling phases and five settings; %0d results checked",
             words_sent, results_seen);
    $display("frames: %0d good, %0d empty, %0d bad checksum; %0d mismatches",
             good_frames, empty_frames, sum_errors, mismatches);
    if (mismatches == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
